/* hdl/sap_pkg.sv */
// ----------------------------------------------------------------------------
// sap_pkg
// Shared types and constants of the absolute-angle stepper positioner.
// ----------------------------------------------------------------------------
package sap_pkg;

  // Field widths
  localparam int OP_W        = 2;
  localparam int ANGLE_CMD_W = 16;
  localparam int SPR_W       = 16;
  localparam int HP_W        = 16;
  localparam int REMAIN_W    = 16;
  localparam int ANGLE_W     = 9;
  localparam int DEG_W       = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // Default for the position register width
  localparam int STEP_BITS_DEF = 16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ANGLE = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_REV = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TORQUE   = 2'd2;

  // Configuration reset values
  localparam logic [SPR_W-1:0] SPR_RESET  = 16'd3200;
  localparam logic [HP_W-1:0]  HP_RESET   = 16'd40;
  localparam logic             HOLD_RESET = 1'b1;

  // Motion direction codes
  localparam logic [1:0] RUN_STOP = 2'd0;
  localparam logic [1:0] RUN_CW   = 2'd1;
  localparam logic [1:0] RUN_CCW  = 2'd2;

  // Divider geometry: numerator widths per division kind, divisor width
  localparam int DEG_NUM_W = 17;
  localparam int TGT_NUM_W = 25;
  localparam int ANG_NUM_W = 26;
  localparam int DIV_DEN_W = 17;
  localparam int DIV_QUO_W = 17;

  // Division by 360: drop the factor 8, then multiply by ceil(2^28 / 45)
  localparam int                   RCP_PRE   = 3;
  localparam int                   RCP_MUL_W = 23;
  localparam logic [RCP_MUL_W-1:0] RCP_MUL   = 23'd5965233;
  localparam int                   RCP_SHIFT = 28;

  // Arithmetic constants
  localparam logic [DEG_W-1:0]     DEG_TURN   = 9'd360;
  localparam logic [DEG_NUM_W-1:0] DEG_BIAS   = 17'd352;
  localparam logic [TGT_NUM_W-1:0] TGT_ROUND  = 25'd180;
  localparam logic [9:0]           ANG_SCALE  = 10'd720;

  // Division kinds
  typedef enum logic [1:0] {
    DK_POS,
    DK_DEG,
    DK_TGT,
    DK_ANG
  } div_kind_t;

  // Controller to datapath commands
  typedef struct packed {
    logic      capture;
    logic      div_go;
    div_kind_t kind;
    logic      apply;
    logic      out_load;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            div_done;
  } dp_sts_t;

  // One result transaction
  typedef struct packed {
    logic                pulse;
    logic                direction;
    logic                drive_enable;
    logic                moving;
    logic [REMAIN_W-1:0] steps_left;
    logic [ANGLE_W-1:0]  angle_now;
  } out_item_t;

endpackage

/* hdl/sap_intf.sv */
// ----------------------------------------------------------------------------
// sap_in_if / sap_out_if
// Valid/ready channels for commands in and status results out.
// ----------------------------------------------------------------------------
interface sap_in_if;
  logic                                valid;
  logic                                ready;
  logic [sap_pkg::OP_W-1:0]            op;
  logic signed [sap_pkg::ANGLE_CMD_W-1:0] angle_cmd;

  modport source (output valid, op, angle_cmd, input ready);
  modport sink (input valid, op, angle_cmd, output ready);
endinterface

interface sap_out_if;
  logic                            valid;
  logic                            ready;
  logic                            pulse;
  logic                            direction;
  logic                            drive_enable;
  logic                            moving;
  logic [sap_pkg::REMAIN_W-1:0]    steps_left;
  logic [sap_pkg::ANGLE_W-1:0]     angle_now;

  modport source (output valid, pulse, direction, drive_enable, moving, steps_left,
                  angle_now, input ready);
  modport sink (input valid, pulse, direction, drive_enable, moving, steps_left,
                angle_now, output ready);
endinterface

/* hdl/sap_div.sv */
// ----------------------------------------------------------------------------
// sap_div
// Restoring divider, one quotient bit per cycle, numerator left-aligned.
// ----------------------------------------------------------------------------
module sap_div #(
  parameter int NUM_W = sap_pkg::ANG_NUM_W,
  parameter int CNT_W = $clog2(NUM_W + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [NUM_W-1:0]              num,
  input  logic [sap_pkg::DIV_DEN_W-1:0] den,
  input  logic [CNT_W-1:0]              len,
  output logic                          done,
  output logic [sap_pkg::DIV_QUO_W-1:0] quo,
  output logic [sap_pkg::DIV_DEN_W-1:0] rem
);

  localparam int DEN_W = sap_pkg::DIV_DEN_W;
  localparam int QUO_W = sap_pkg::DIV_QUO_W;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [QUO_W-1:0] quo_r;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             fits;
  logic [DEN_W-1:0] rem_nxt;

  // One restoring step: shift in the next numerator bit, subtract if it fits
  always_comb begin
    rem_sh  = {rem_r, num_r[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, den_r};
    fits    = (rem_sh >= {1'b0, den_r});
    rem_nxt = fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
  end

  // Sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= len;
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operands and partial results
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[QUO_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

/* hdl/sap_dpath.sv */
// ----------------------------------------------------------------------------
// sap_dpath
// Configuration, motion state, shared divider and the result register.
// ----------------------------------------------------------------------------
module sap_dpath #(
  parameter int STEP_BITS = sap_pkg::STEP_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  sap_pkg::ctrl_cmd_t                     cmd,
  output sap_pkg::dp_sts_t                       sts,
  input  logic [sap_pkg::OP_W-1:0]               in_op,
  input  logic signed [sap_pkg::ANGLE_CMD_W-1:0] in_angle_cmd,
  input  logic                                   cfg_we,
  input  logic [sap_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [sap_pkg::CFG_DATA_W-1:0]         cfg_data,
  output sap_pkg::out_item_t                     item
);

  localparam int SPR_W     = sap_pkg::SPR_W;
  localparam int HP_W      = sap_pkg::HP_W;
  localparam int REMAIN_W  = sap_pkg::REMAIN_W;
  localparam int DEG_W     = sap_pkg::DEG_W;
  localparam int ANGLE_W   = sap_pkg::ANGLE_W;
  localparam int DEN_W     = sap_pkg::DIV_DEN_W;
  localparam int QUO_W     = sap_pkg::DIV_QUO_W;
  localparam int DEG_NUM_W = sap_pkg::DEG_NUM_W;
  localparam int TGT_NUM_W = sap_pkg::TGT_NUM_W;
  localparam int ANG_NUM_W = sap_pkg::ANG_NUM_W;
  localparam int NUM_W     = (STEP_BITS > ANG_NUM_W) ? STEP_BITS : ANG_NUM_W;
  localparam int CNT_W     = $clog2(NUM_W + 1);
  localparam int RCP_Y_W   = TGT_NUM_W - sap_pkg::RCP_PRE;
  localparam int RCP_P_W   = RCP_Y_W + sap_pkg::RCP_MUL_W;

  // Configuration registers
  logic [SPR_W-1:0] spr_r;
  logic [HP_W-1:0]  hp_r;
  logic             hold_r;

  // Motion state
  logic [STEP_BITS-1:0] pos_r, pos_nxt;
  logic [SPR_W-1:0]     tgt_r, tgt_nxt;
  logic                 known_r, known_nxt;
  logic [REMAIN_W-1:0]  remaining_r, remaining_nxt;
  logic [1:0]           run_dir_r, run_dir_nxt;
  logic                 pulse_r, pulse_nxt;
  logic                 dir_r, dir_nxt;
  logic                 en_r, en_nxt;
  logic [HP_W-1:0]      tick_r, tick_nxt;

  // Per-transaction working registers
  logic [sap_pkg::OP_W-1:0]        op_r;
  logic [sap_pkg::ANGLE_CMD_W-1:0] ang_r;
  logic [SPR_W-1:0]                cur_r;
  logic [DEG_W-1:0]                deg_r;
  logic [QUO_W-1:0]                tq_r;
  logic [ANGLE_W-1:0]              angle_r;
  sap_pkg::div_kind_t              kind_r;
  sap_pkg::out_item_t              item_r;

  // Divider hookup
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic [CNT_W-1:0] div_len;
  logic             sdiv_go;
  logic             sdiv_done;
  logic             div_done;
  logic [QUO_W-1:0] div_quo;
  logic [DEN_W-1:0] div_rem;

  // Division by 360 through the reciprocal
  logic                 rcp_go;
  logic [TGT_NUM_W-1:0] rcp_num;
  logic [RCP_Y_W-1:0]   rcp_y_r;
  logic [DEG_W-1:0]     rcp_x_r;
  logic                 rcp_busy_r;
  logic                 rcp_done_r;
  logic [RCP_P_W-1:0]   rcp_prod;
  logic [QUO_W-1:0]     rcp_q_r;
  logic [DEG_W-1:0]     rcp_rem;

  // Derived values
  logic [SPR_W-1:0]     spr_eff;
  logic [HP_W-1:0]      hp_eff;
  logic [DEG_NUM_W-1:0] deg_num;
  logic [TGT_NUM_W-1:0] tgt_num;
  logic [ANG_NUM_W-1:0] ang_num;
  logic [QUO_W-1:0]     tq_red;
  logic [SPR_W-1:0]     t_new;
  logic [SPR_W:0]       diff_w;
  logic [SPR_W-1:0]     diff;
  logic                 far;
  logic                 repeat_cmd;
  logic [HP_W-1:0]      tick_inc;
  logic                 hp_end;
  logic [SPR_W-1:0]     p_step;
  logic [ANGLE_W-1:0]   q_ang;

  // Clamp the degenerate register values
  assign spr_eff = (spr_r < SPR_W'(2)) ? SPR_W'(2) : spr_r;
  assign hp_eff  = (hp_r == '0) ? HP_W'(1) : hp_r;

  // Numerators: biased angle, scaled target, scaled position
  assign deg_num = {1'b0, ~ang_r[sap_pkg::ANGLE_CMD_W-1], ang_r[sap_pkg::ANGLE_CMD_W-2:0]}
                   + sap_pkg::DEG_BIAS;
  assign tgt_num = TGT_NUM_W'(deg_r) * TGT_NUM_W'(spr_eff) + sap_pkg::TGT_ROUND;
  assign ang_num = ANG_NUM_W'(cur_r) * ANG_NUM_W'(sap_pkg::ANG_SCALE) + ANG_NUM_W'(spr_eff);

  // Route reductions by steps_per_rev to the serial divider, by 360 to the reciprocal
  assign sdiv_go = cmd.div_go &&
                   ((cmd.kind == sap_pkg::DK_POS) || (cmd.kind == sap_pkg::DK_ANG));
  assign rcp_go  = cmd.div_go && !sdiv_go;

  // Select and left-align the operands of the next serial division
  always_comb begin
    if (cmd.kind == sap_pkg::DK_POS) begin
      div_num = NUM_W'(pos_r) << (NUM_W - STEP_BITS);
      div_den = {1'b0, spr_eff};
      div_len = CNT_W'(STEP_BITS);
    end else begin
      div_num = NUM_W'(ang_num) << (NUM_W - ANG_NUM_W);
      div_den = {spr_eff, 1'b0};
      div_len = CNT_W'(ANG_NUM_W);
    end
  end

  sap_div #(
    .NUM_W (NUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sdiv_go),
    .num   (div_num),
    .den   (div_den),
    .len   (div_len),
    .done  (sdiv_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // Divide by 360: drop the factor 8, multiply by the reciprocal of 45
  assign rcp_num  = (cmd.kind == sap_pkg::DK_DEG) ? TGT_NUM_W'(deg_num) : tgt_num;
  assign rcp_prod = RCP_P_W'(rcp_y_r) * RCP_P_W'(sap_pkg::RCP_MUL);
  assign rcp_rem  = rcp_x_r - DEG_W'(rcp_q_r[DEG_W-1:0] * sap_pkg::DEG_TURN);

  // Reciprocal sequence: load, multiply, then flag the quotient ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rcp_busy_r <= 1'b0;
      rcp_done_r <= 1'b0;
    end else begin
      rcp_busy_r <= rcp_go;
      rcp_done_r <= rcp_busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rcp_go) begin
      rcp_y_r <= rcp_num[TGT_NUM_W-1:sap_pkg::RCP_PRE];
      rcp_x_r <= rcp_num[DEG_W-1:0];
    end
    if (rcp_busy_r) begin
      rcp_q_r <= rcp_prod[sap_pkg::RCP_SHIFT +: QUO_W];
    end
  end

  assign div_done = sdiv_done || rcp_done_r;

  // Angle command: reduce target into the revolution, pick the shorter way
  always_comb begin
    tq_red     = (tq_r >= {1'b0, spr_eff}) ? (tq_r - {1'b0, spr_eff}) : tq_r;
    t_new      = tq_red[SPR_W-1:0];
    diff_w     = (t_new >= cur_r) ? ({1'b0, t_new} - {1'b0, cur_r})
                                  : ({1'b0, t_new} + {1'b0, spr_eff} - {1'b0, cur_r});
    diff       = diff_w[SPR_W-1:0];
    far        = (diff > (spr_eff >> 1));
    repeat_cmd = known_r && (tgt_r == t_new) && (remaining_r != '0);
  end

  // Timer tick: half-period end and the position after one step
  always_comb begin
    tick_inc = tick_r + HP_W'(1);
    hp_end   = (tick_inc >= hp_eff) || (tick_inc == '0);
    if (run_dir_r == sap_pkg::RUN_CW) begin
      p_step = (({1'b0, cur_r} + (SPR_W + 1)'(1)) >= {1'b0, spr_eff}) ? '0
                                                                     : cur_r + SPR_W'(1);
    end else begin
      p_step = (cur_r == '0) ? spr_eff - SPR_W'(1) : cur_r - SPR_W'(1);
    end
  end

  // Next motion state
  always_comb begin
    pos_nxt       = pos_r;
    tgt_nxt       = tgt_r;
    known_nxt     = known_r;
    remaining_nxt = remaining_r;
    run_dir_nxt   = run_dir_r;
    pulse_nxt     = pulse_r;
    dir_nxt       = dir_r;
    en_nxt        = en_r;
    tick_nxt      = tick_r;
    if (cmd.apply) begin
      case (op_r)
        sap_pkg::OP_ANGLE: begin
          if (!repeat_cmd) begin
            tgt_nxt   = t_new;
            known_nxt = 1'b1;
            if (diff != '0) begin
              if (far) begin
                run_dir_nxt   = sap_pkg::RUN_CCW;
                dir_nxt       = 1'b1;
                remaining_nxt = REMAIN_W'(spr_eff - diff);
              end else begin
                run_dir_nxt   = sap_pkg::RUN_CW;
                dir_nxt       = 1'b0;
                remaining_nxt = REMAIN_W'(diff);
              end
              en_nxt = 1'b1;
            end
          end
        end
        sap_pkg::OP_TICK: begin
          tick_nxt = hp_end ? '0 : tick_inc;
          if (hp_end) begin
            if ((run_dir_r == sap_pkg::RUN_STOP) || (remaining_r == '0)) begin
              pulse_nxt = 1'b0;
            end else if (!pulse_r) begin
              pulse_nxt = 1'b1;
            end else begin
              // Falling edge: count one step
              pulse_nxt     = 1'b0;
              remaining_nxt = remaining_r - REMAIN_W'(1);
              pos_nxt       = STEP_BITS'(p_step);
              if (remaining_r == REMAIN_W'(1)) begin
                run_dir_nxt = sap_pkg::RUN_STOP;
                if (known_r) begin
                  pos_nxt = STEP_BITS'(tgt_r);
                end
                if (!hold_r) begin
                  en_nxt = 1'b0;
                end
              end
            end
          end
        end
        sap_pkg::OP_STOP: begin
          run_dir_nxt   = sap_pkg::RUN_STOP;
          remaining_nxt = '0;
          en_nxt        = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Configuration and motion state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spr_r       <= sap_pkg::SPR_RESET;
      hp_r        <= sap_pkg::HP_RESET;
      hold_r      <= sap_pkg::HOLD_RESET;
      pos_r       <= '0;
      tgt_r       <= '0;
      known_r     <= 1'b0;
      remaining_r <= '0;
      run_dir_r   <= sap_pkg::RUN_STOP;
      pulse_r     <= 1'b0;
      dir_r       <= 1'b0;
      en_r        <= 1'b0;
      tick_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sap_pkg::REG_STEPS_PER_REV: spr_r  <= cfg_data[SPR_W-1:0];
          sap_pkg::REG_HALF_PERIOD:   hp_r   <= cfg_data[HP_W-1:0];
          sap_pkg::REG_HOLD_TORQUE:   hold_r <= cfg_data[0];
          default: begin
          end
        endcase
      end
      pos_r       <= pos_nxt;
      tgt_r       <= tgt_nxt;
      known_r     <= known_nxt;
      remaining_r <= remaining_nxt;
      run_dir_r   <= run_dir_nxt;
      pulse_r     <= pulse_nxt;
      dir_r       <= dir_nxt;
      en_r        <= en_nxt;
      tick_r      <= tick_nxt;
    end
  end

  // Divider results: store per kind
  assign q_ang = div_quo[ANGLE_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_op;
      ang_r <= in_angle_cmd;
    end
    if (cmd.div_go) begin
      kind_r <= cmd.kind;
    end
    if (div_done) begin
      case (kind_r)
        sap_pkg::DK_POS: cur_r <= div_rem[SPR_W-1:0];
        sap_pkg::DK_DEG: deg_r <= rcp_rem;
        sap_pkg::DK_TGT: tq_r  <= rcp_q_r;
        default: begin
          angle_r <= (q_ang >= ANGLE_W'(sap_pkg::DEG_TURN)) ?
                     q_ang - ANGLE_W'(sap_pkg::DEG_TURN) : q_ang;
        end
      endcase
    end
    // Result register
    if (cmd.out_load) begin
      item_r.pulse        <= pulse_r;
      item_r.direction    <= dir_r;
      item_r.drive_enable <= en_r;
      item_r.moving       <= (remaining_r != '0) && (run_dir_r != sap_pkg::RUN_STOP);
      item_r.steps_left   <= remaining_r;
      item_r.angle_now    <= angle_r;
    end
  end

  assign item         = item_r;
  assign sts.op       = op_r;
  assign sts.div_done = div_done;

endmodule

/* hdl/sap_ctrl.sv */
// ----------------------------------------------------------------------------
// sap_ctrl
// Sequencer: runs the divisions, applies the operation, hands off the result.
// ----------------------------------------------------------------------------
module sap_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  sap_pkg::dp_sts_t   sts,
  output sap_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_APPLY,
    ST_OUT
  } state_t;

  state_t             state_r, state_nxt;
  sap_pkg::div_kind_t kind_r, kind_nxt;
  logic               late_r, late_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               load;

  assign in_ready = (state_r == ST_IDLE);
  assign load     = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  // Commands to the datapath
  always_comb begin
    cmd.capture  = in_valid && in_ready;
    cmd.div_go   = (state_r == ST_DIV_GO);
    cmd.kind     = kind_r;
    cmd.apply    = (state_r == ST_APPLY);
    cmd.out_load = load;
  end

  // Next state
  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    late_nxt      = late_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DIV_GO;
          kind_nxt  = sap_pkg::DK_POS;
          late_nxt  = 1'b0;
        end
      end
      ST_DIV_GO: begin
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (sts.div_done) begin
          unique case (kind_r)
            sap_pkg::DK_POS: begin
              if (late_r) begin
                state_nxt = ST_DIV_GO;
                kind_nxt  = sap_pkg::DK_ANG;
              end else if (sts.op == sap_pkg::OP_ANGLE) begin
                state_nxt = ST_DIV_GO;
                kind_nxt  = sap_pkg::DK_DEG;
              end else begin
                state_nxt = ST_APPLY;
              end
            end
            sap_pkg::DK_DEG: begin
              state_nxt = ST_DIV_GO;
              kind_nxt  = sap_pkg::DK_TGT;
            end
            sap_pkg::DK_TGT: state_nxt = ST_APPLY;
            sap_pkg::DK_ANG: state_nxt = ST_OUT;
            default: state_nxt = ST_OUT;
          endcase
        end
      end
      ST_APPLY: begin
        // Re-reduce the new position for the reported angle
        state_nxt = ST_DIV_GO;
        kind_nxt  = sap_pkg::DK_POS;
        late_nxt  = 1'b1;
      end
      ST_OUT: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      kind_r      <= sap_pkg::DK_POS;
      late_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      late_r      <= late_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* hdl/stepper_absolute_angle_positioner.sv */
// One transaction at a time; the next is taken in the cycle after the result is
// registered at the earliest.
// Synchronous active-low reset: motor stopped, driver off, position zero,
// registers back to 3200 steps, 40 ticks, hold on.
// ----------------------------------------------------------------------------
// stepper_absolute_angle_positioner
// Step/direction positioner: converts absolute angle commands to step moves
// and steps the motor on divided timer ticks.
// ----------------------------------------------------------------------------
module stepper_absolute_angle_positioner #(
  parameter int STEP_BITS = sap_pkg::STEP_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  sap_in_if.sink                         in_ch,
  sap_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [sap_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sap_pkg::CFG_DATA_W-1:0] cfg_data
);

  sap_pkg::ctrl_cmd_t cmd;
  sap_pkg::dp_sts_t   sts;
  sap_pkg::out_item_t item;
  logic               in_ready;
  logic               out_valid;

  sap_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sap_dpath #(
    .STEP_BITS (STEP_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_op        (in_ch.op),
    .in_angle_cmd (in_ch.angle_cmd),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item         (item)
  );

  // Drive the channels
  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid;
  assign out_ch.pulse        = item.pulse;
  assign out_ch.direction    = item.direction;
  assign out_ch.drive_enable = item.drive_enable;
  assign out_ch.moving       = item.moving;
  assign out_ch.steps_left   = item.steps_left;
  assign out_ch.angle_now    = item.angle_now;

endmodule

/* test/stepper_absolute_angle_positioner_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stepper_absolute_angle_positioner_checker
// Watches the command, status and register ports of the positioner. It keeps
// its own copy of the motion state, works out the status that each accepted
// command must produce, and compares every status transaction in order.
// ----------------------------------------------------------------------------
module stepper_absolute_angle_positioner_checker #(
  parameter int STEP_BITS = sap_pkg::STEP_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  sap_in_if                              in_ch,
  sap_out_if                             out_ch,
  input  logic                           cfg_we,
  input  logic [sap_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sap_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             status_outstanding,
  output int                             status_checked,
  output int                             moves_finished
);
  import sap_pkg::*;

  localparam int MAX_REPORTS = 30;

  // Register copies
  logic [SPR_W-1:0] spr_reg;
  logic [HP_W-1:0]  hp_reg;
  logic             hold_reg;

  // Motion state copies
  logic [STEP_BITS-1:0] pos;
  logic [15:0]          tgt;
  logic                 tgt_known;
  logic [REMAIN_W-1:0]  remain;
  logic [1:0]           run;
  logic                 pulse_q;
  logic                 dir_q;
  logic                 en_q;
  logic [15:0]          tick_cnt;

  out_item_t status_due[$];

  function automatic int unsigned spr_eff();
    return (spr_reg < 2) ? 2 : spr_reg;
  endfunction

  function automatic int unsigned pos_in_rev();
    int unsigned p;
    p = pos;
    return p % spr_eff();
  endfunction

  // Toggle the pulse line; count one step on each falling edge
  function automatic void end_half_period();
    int unsigned s;
    int unsigned p;
    if (run == RUN_STOP || remain == 0) begin
      pulse_q = 1'b0;
      return;
    end
    if (!pulse_q) begin
      pulse_q = 1'b1;
      return;
    end
    pulse_q = 1'b0;
    remain  = remain - 1'b1;
    s = spr_eff();
    p = pos_in_rev();
    if (run == RUN_CW) p = (p + 1 >= s) ? 0 : p + 1;
    else               p = (p == 0) ? s - 1 : p - 1;
    pos = p[STEP_BITS-1:0];
    if (remain == 0) begin
      run = RUN_STOP;
      if (tgt_known) pos = STEP_BITS'(tgt);
      if (!hold_reg) en_q = 1'b0;
      moves_finished++;
    end
  endfunction

  // Wrap the angle, round to a step and pick the shorter way round
  function automatic void take_angle(logic signed [ANGLE_CMD_W-1:0] a);
    int          deg;
    int unsigned s;
    int unsigned t;
    int unsigned cur;
    int unsigned diff;
    s   = spr_eff();
    deg = a;
    deg = deg % 360;
    if (deg < 0) deg += 360;
    t = ((deg * s + 180) / 360) % s;
    if (tgt_known && tgt == t && remain > 0) return;
    cur  = pos_in_rev();
    diff = (t >= cur) ? t - cur : t + s - cur;
    tgt       = t[15:0];
    tgt_known = 1'b1;
    if (diff == 0) return;
    if (diff > s / 2) begin
      run    = RUN_CCW;
      dir_q  = 1'b1;
      remain = REMAIN_W'(s - diff);
    end else begin
      run    = RUN_CW;
      dir_q  = 1'b0;
      remain = REMAIN_W'(diff);
    end
    en_q = 1'b1;
  endfunction

  // Apply one command and return the status it reports
  function automatic out_item_t next_status(logic [OP_W-1:0] op,
                                            logic signed [ANGLE_CMD_W-1:0] a);
    out_item_t   r;
    int unsigned hp;
    int unsigned s;
    case (op)
      OP_ANGLE: take_angle(a);
      OP_TICK: begin
        hp = (hp_reg == 0) ? 1 : hp_reg;
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= hp || tick_cnt == 0) begin
          tick_cnt = '0;
          end_half_period();
        end
      end
      OP_STOP: begin
        run    = RUN_STOP;
        remain = '0;
        en_q   = 1'b0;
      end
      default: ;
    endcase
    s = spr_eff();
    r.pulse        = pulse_q;
    r.direction    = dir_q;
    r.drive_enable = en_q;
    r.moving       = (remain > 0 && run != RUN_STOP);
    r.steps_left   = remain;
    r.angle_now    = ANGLE_W'(((pos_in_rev() * 720 + s) / (2 * s)) % 360);
    return r;
  endfunction

  // Track registers, predict on each command, compare each status
  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (!rst_n) begin
      spr_reg   = SPR_RESET;
      hp_reg    = HP_RESET;
      hold_reg  = HOLD_RESET;
      pos       = '0;
      tgt       = '0;
      tgt_known = 1'b0;
      remain    = '0;
      run       = RUN_STOP;
      pulse_q   = 1'b0;
      dir_q     = 1'b0;
      en_q      = 1'b0;
      tick_cnt  = '0;
      status_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_STEPS_PER_REV: spr_reg  = cfg_data;
          REG_HALF_PERIOD:   hp_reg   = cfg_data;
          REG_HOLD_TORQUE:   hold_reg = cfg_data[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        status_due.push_back(next_status(in_ch.op, in_ch.angle_cmd));
      if (out_ch.valid && out_ch.ready) begin
        got.pulse        = out_ch.pulse;
        got.direction    = out_ch.direction;
        got.drive_enable = out_ch.drive_enable;
        got.moving       = out_ch.moving;
        got.steps_left   = out_ch.steps_left;
        got.angle_now    = out_ch.angle_now;
        if (status_due.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: status with nothing expected: pulse=%0d dir=%0d en=%0d mov=%0d left=%0d angle=%0d",
                     $time, got.pulse, got.direction, got.drive_enable, got.moving,
                     got.steps_left, got.angle_now);
        end else begin
          want = status_due.pop_front();
          status_checked++;
          if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("%0t: status mismatch, expected pulse=%0d dir=%0d en=%0d mov=%0d left=%0d angle=%0d",
                       $time, want.pulse, want.direction, want.drive_enable, want.moving,
                       want.steps_left, want.angle_now);
              $display("%0t:                   actual pulse=%0d dir=%0d en=%0d mov=%0d left=%0d angle=%0d",
                       $time, got.pulse, got.direction, got.drive_enable, got.moving,
                       got.steps_left, got.angle_now);
            end
          end
        end
      end
    end
    status_outstanding = status_due.size();
  end

endmodule

/* test/stepper_absolute_angle_positioner_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stepper_absolute_angle_positioner_tb
// Drives angle, tick and stop commands into the positioner across a series of
// register settings: a short directed walk through the corner cases, then
// random move sequences with bursty commands and a stalling status sink.
// The checker beside the block predicts and compares every status.
// ----------------------------------------------------------------------------
module stepper_absolute_angle_positioner_tb;
  import sap_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int N_PHASES    = 11;
  localparam int TICK_CAP    = 120;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Random phases: steps per rev, half period, hold torque, command count
  localparam int unsigned PH_SPR[N_PHASES]   = '{2, 0, 1, 12, 24, 7, 65535, 3200, 65535, 5, 16};
  localparam int unsigned PH_HP[N_PHASES]    = '{1, 0, 2, 0, 3, 1, 1, 1, 65535, 2, 1};
  localparam int unsigned PH_HOLD[N_PHASES]  = '{0, 1, 0, 1, 0, 1, 1, 0, 0, 1, 0};
  localparam int          PH_ITEMS[N_PHASES] = '{220, 200, 200, 220, 220, 220, 60, 80, 40,
                                                 220, 220};

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sap_in_if  in_ch();
  sap_out_if out_ch();

  int fail_count;
  int status_outstanding;
  int status_checked;
  int moves_finished;
  int cycle_count;
  int cmds_sent;
  int burst_left;
  int settings_used;
  int unsigned spr_set;
  int unsigned hp_set;
  logic signed [ANGLE_CMD_W-1:0] last_angle;

  stepper_absolute_angle_positioner #(
    .STEP_BITS(STEP_BITS_DEF)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  stepper_absolute_angle_positioner_checker #(
    .STEP_BITS(STEP_BITS_DEF)
  ) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_ch             (in_ch),
    .out_ch            (out_ch),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .status_outstanding(status_outstanding),
    .status_checked    (status_checked),
    .moves_finished    (moves_finished)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("stepper_absolute_angle_positioner test failed");
      $finish;
    end
  end

  // Status sink: switch between four stall patterns, each held for a random span
  initial begin
    int mode;
    int span;
    out_ch.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 200);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0:       out_ch.ready = 1'b1;
          1:       out_ch.ready = $urandom_range(0, 1);
          2:       out_ch.ready = ($urandom_range(0, 7) == 0);
          default: out_ch.ready = ($urandom_range(0, 31) == 0);
        endcase
      end
    end
  end

  // Send one transaction; hold valid through a burst, drop it for a gap after
  task automatic send_cmd(logic [OP_W-1:0] op, logic signed [ANGLE_CMD_W-1:0] angle);
    in_ch.op        = op;
    in_ch.angle_cmd = angle;
    in_ch.valid     = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    cmds_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 120)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
  endtask

  // Hold off until every expected status is back and the block is idle
  task automatic drain();
    in_ch.valid = 1'b0;
    while (status_outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic set_config(int unsigned spr, int unsigned hp, int unsigned hold);
    drain();
    write_reg(REG_STEPS_PER_REV, spr);
    write_reg(REG_HALF_PERIOD, hp);
    write_reg(REG_HOLD_TORQUE, hold);
    spr_set = spr;
    hp_set  = hp;
    settings_used++;
  endtask

  // Ticks enough to finish the longest move at the current setting, capped at TICK_CAP
  function automatic int move_ticks();
    longint s;
    longint h;
    longint b;
    s = (spr_set < 2) ? 2 : spr_set;
    h = (hp_set == 0) ? 1 : hp_set;
    b = s * h + h;
    return (b > TICK_CAP) ? TICK_CAP : int'(b);
  endfunction

  function automatic logic signed [ANGLE_CMD_W-1:0] pick_angle(
      logic signed [ANGLE_CMD_W-1:0] prev);
    int v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 65535) - 32768;
      1: v = $urandom_range(0, 359);
      2: v = (int'($urandom_range(0, 180)) - 90) * 360 + int'($urandom_range(0, 2)) - 1;
      default: v = int'(prev) + 180;
    endcase
    return v[ANGLE_CMD_W-1:0];
  endfunction

  // Mostly whole moves: a command and the ticks to finish it, plus noise
  task automatic random_moves(int n_cmds);
    int done;
    int sel;
    int nt;
    done = 0;
    while (done < n_cmds) begin
      sel = $urandom_range(0, 99);
      nt  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, move_ticks()) : move_ticks();
      if (sel < 65) begin
        last_angle = pick_angle(last_angle);
        send_cmd(OP_ANGLE, last_angle);
        done++;
      end else if (sel < 75) begin
        send_cmd(OP_ANGLE, last_angle);
        done++;
        nt = nt / 2;
      end else if (sel < 85) begin
        send_cmd(OP_STOP, ANGLE_CMD_W'($urandom));
        done++;
        nt = $urandom_range(0, 4);
      end else if (sel < 92) begin
        send_cmd(OP_UNUSED, ANGLE_CMD_W'($urandom));
        nt = 0;
      end else begin
        nt = $urandom_range(1, 20);
      end
      repeat (nt) send_cmd(OP_TICK, ANGLE_CMD_W'($urandom));
      done += nt;
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_STEPS_PER_REV;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.op        = OP_TICK;
    in_ch.angle_cmd = '0;
    burst_left      = 1;
    spr_set         = SPR_RESET;
    hp_set          = HP_RESET;
    last_angle      = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Idle behavior at reset values
    send_cmd(OP_UNUSED, 16'sh7fff);
    send_cmd(OP_TICK, 16'sh0000);
    send_cmd(OP_STOP, -16'sd1);

    // Eight steps per turn, every tick ends a half period, no holding torque
    set_config(8, 0, 0);
    send_cmd(OP_ANGLE, 16'sd32767);     // wraps to step zero: already there
    send_cmd(OP_ANGLE, 16'sd180);       // exactly half a turn: clockwise
    send_cmd(OP_ANGLE, 16'sd180);       // repeat while moving: ignored
    repeat (2) send_cmd(OP_TICK, 16'sd0);
    send_cmd(OP_ANGLE, 16'sd45);        // target is where we stand: keep moving
    repeat (6) send_cmd(OP_TICK, 16'sd0);
    send_cmd(OP_ANGLE, 16'sd300);       // shorter way is counter-clockwise
    send_cmd(OP_TICK, 16'sd0);
    send_cmd(OP_STOP, 16'sd0);
    send_cmd(OP_TICK, 16'sd0);          // pulse drops while stopped
    send_cmd(OP_ANGLE, -16'sd32768);
    repeat (2) send_cmd(OP_TICK, 16'sd0);

    // Two steps per turn: half-up rounding, then a lowered half period
    set_config(2, 5, 1);
    send_cmd(OP_ANGLE, 16'sd90);
    send_cmd(OP_ANGLE, 16'sd89);
    repeat (3) send_cmd(OP_TICK, 16'sd0);
    set_config(2, 2, 1);
    send_cmd(OP_TICK, 16'sd0);

    for (int i = 0; i < N_PHASES; i++) begin
      set_config(PH_SPR[i], PH_HP[i], PH_HOLD[i]);
      random_moves(PH_ITEMS[i]);
    end

    drain();
    repeat (150) @(negedge clk);

    $display("Covered %0d transactions over %0d register settings", cmds_sent, settings_used);
    $display("Checked %0d status transactions, %0d moves ran to completion",
             status_checked, moves_finished);
    if (fail_count == 0 && status_outstanding == 0) begin
      $display("stepper_absolute_angle_positioner test passed");
    end else begin
      $display("stepper_absolute_angle_positioner test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/sap_pkg.sv
hdl/sap_intf.sv
hdl/sap_div.sv
hdl/sap_dpath.sv
hdl/sap_ctrl.sv
hdl/stepper_absolute_angle_positioner.sv
test/stepper_absolute_angle_positioner_checker.sv
test/stepper_absolute_angle_positioner_tb.sv
